// ===== rtl/core/nmpl_pkg.sv =====
// Shared types, constants and helpers for the normal-map pixel lighting block.
package nmpl_pkg;

   localparam int unsigned VecWidth    = 16;
   localparam int unsigned ColorWidth  = 24;
   localparam int unsigned SqWidth     = 34;
   localparam int unsigned LenWidth    = 17;
   localparam int unsigned QuoWidth    = 13;
   localparam int unsigned NumWidth    = 29;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned FifoDepth   = 4;
   localparam int unsigned OutDepth    = 4;

   localparam logic [ColorWidth-1:0] MagentaColor = 24'hFF00FF;

   localparam logic [CsrIdxWidth-1:0] CsrLightX  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrLightY  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrLightZ  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CsrAmbient = 2'd3;

   typedef struct packed {
      logic                  magenta;
      logic [ColorWidth-1:0] base;
      logic signed [VecWidth-1:0] nx;
      logic signed [VecWidth-1:0] ny;
      logic signed [VecWidth-1:0] nz;
   } work_type;

   // normal-map channel decode: trunc((8192*c - 1044480)/255) toward zero
   function automatic logic signed [VecWidth-1:0] decode_channel(input logic [7:0] c);
      logic signed [22:0] num;
      logic [21:0] mag;
      logic [40:0] prod;
      logic [12:0] q;
      begin
         num = 23'(signed'({1'b0, c, 13'd0})) - 23'sd1044480;
         mag = num[22] ? 22'(-num) : num[21:0];
         // divide by 255 as a multiply by ceil(2^28/255); exact while mag < 2^20
         prod = 41'(mag) * 41'(21'd1052689);
         q = prod[40:28];
         decode_channel = num[22] ? -16'(signed'({3'b0, q})) : 16'(signed'({3'b0, q}));
      end
   endfunction

endpackage

// ===== rtl/core/nmpl_front.sv =====
// Front part: accepts words, selects and decodes the normal.
module nmpl_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [nmpl_pkg::ColorWidth-1:0] base_texel,
   input  logic                           base_present,
   input  logic [nmpl_pkg::ColorWidth-1:0] bump_texel,
   input  logic                           bump_present,
   input  logic signed [15:0]             normal_x,
   input  logic signed [15:0]             normal_y,
   input  logic signed [15:0]             normal_z,
   output logic                           out_valid,
   output nmpl_pkg::work_type             out_work
);
   import nmpl_pkg::*;

   logic     valid_ff, valid_in;
   work_type work_ff, work_in;
   logic [7:0] rom_idx [3];
   logic signed [VecWidth-1:0] dec [3];

   assign rom_idx[0] = bump_texel[23:16];
   assign rom_idx[1] = bump_texel[15:8];
   assign rom_idx[2] = bump_texel[7:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dec[i] = decode_channel(rom_idx[i]);
      end
      valid_in = in_valid;
      work_in.magenta = !base_present;
      work_in.base = base_texel;
      work_in.nx = bump_present ? dec[0] : normal_x;
      work_in.ny = bump_present ? dec[1] : normal_y;
      work_in.nz = bump_present ? dec[2] : normal_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      work_ff <= work_in;
   end

   assign out_valid = valid_ff;
   assign out_work = work_ff;
endmodule

// ===== rtl/core/nmpl_back.sv =====
// Back part: normalize, dot product, light factor and channel scaling pipeline.
module nmpl_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  nmpl_pkg::work_type              in_work,
   input  logic signed [15:0]              light_x,
   input  logic signed [15:0]              light_y,
   input  logic signed [15:0]              light_z,
   input  logic [15:0]                     ambient,
   output logic                            out_valid,
   output logic [nmpl_pkg::ColorWidth-1:0] out_color
);
   import nmpl_pkg::*;

   // stage A: sums of squares (one 16x16 square per term)
   logic                    a_valid_ff;
   work_type                a_work_ff;
   logic [SqWidth-1:0]      a_nss_ff, a_lss_ff;
   logic [31:0] nsq [3];
   logic [31:0] lsq [3];

   always_comb begin
      nsq[0] = 32'(in_work.nx * in_work.nx);
      nsq[1] = 32'(in_work.ny * in_work.ny);
      nsq[2] = 32'(in_work.nz * in_work.nz);
      lsq[0] = 32'(light_x * light_x);
      lsq[1] = 32'(light_y * light_y);
      lsq[2] = 32'(light_z * light_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_work_ff <= in_work;
      a_nss_ff <= SqWidth'(nsq[0]) + SqWidth'(nsq[1]) + SqWidth'(nsq[2]);
      a_lss_ff <= SqWidth'(lsq[0]) + SqWidth'(lsq[1]) + SqWidth'(lsq[2]);
   end

   // stages S: square root, one result bit per stage (17 stages)
   localparam int unsigned SqSteps = LenWidth;
   logic               s_valid_ff [SqSteps+1];
   work_type           s_work_ff  [SqSteps+1];
   logic [SqWidth+1:0] s_nrem_ff  [SqSteps+1];
   logic [LenWidth-1:0] s_nroot_ff [SqSteps+1];
   logic [SqWidth+1:0] s_lrem_ff  [SqSteps+1];
   logic [LenWidth-1:0] s_lroot_ff [SqSteps+1];

   always_comb begin
      s_valid_ff[0] = a_valid_ff;
      s_work_ff[0] = a_work_ff;
      s_nrem_ff[0] = {2'b0, a_nss_ff};
      s_nroot_ff[0] = '0;
      s_lrem_ff[0] = {2'b0, a_lss_ff};
      s_lroot_ff[0] = '0;
   end

   for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
      localparam int unsigned Sh = 2 * (SqSteps - 1 - k);
      logic [SqWidth+1:0] ntrial, ltrial, nsh, lsh;
      always_comb begin
         nsh = s_nrem_ff[k] >> Sh;
         lsh = s_lrem_ff[k] >> Sh;
         ntrial = (SqWidth+2)'({s_nroot_ff[k], 2'b01});
         ltrial = (SqWidth+2)'({s_lroot_ff[k], 2'b01});
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            s_valid_ff[k+1] <= 1'b0;
         end else begin
            s_valid_ff[k+1] <= s_valid_ff[k];
         end
         s_work_ff[k+1] <= s_work_ff[k];
         if (nsh >= ntrial) begin
            s_nrem_ff[k+1] <= s_nrem_ff[k] - (ntrial << Sh);
            s_nroot_ff[k+1] <= {s_nroot_ff[k][LenWidth-2:0], 1'b1};
         end else begin
            s_nrem_ff[k+1] <= s_nrem_ff[k];
            s_nroot_ff[k+1] <= {s_nroot_ff[k][LenWidth-2:0], 1'b0};
         end
         if (lsh >= ltrial) begin
            s_lrem_ff[k+1] <= s_lrem_ff[k] - (ltrial << Sh);
            s_lroot_ff[k+1] <= {s_lroot_ff[k][LenWidth-2:0], 1'b1};
         end else begin
            s_lrem_ff[k+1] <= s_lrem_ff[k];
            s_lroot_ff[k+1] <= {s_lroot_ff[k][LenWidth-2:0], 1'b0};
         end
      end
   end

   // stages D: six restoring dividers |v|*4096/len, one quotient bit per stage.
   // |v| <= len, so the quotient fits 13 bits and the dividend bits above
   // those steps start out as the remainder.
   localparam int unsigned DivSteps = QuoWidth;
   logic               d_valid_ff [DivSteps+1];
   logic               d_mag_ff   [DivSteps+1];
   logic [ColorWidth-1:0] d_base_ff [DivSteps+1];
   logic [LenWidth-1:0] d_nlen_ff [DivSteps+1];
   logic [LenWidth-1:0] d_llen_ff [DivSteps+1];
   logic [5:0]         d_neg_ff   [DivSteps+1];
   logic [NumWidth-1:0] d_num_ff  [DivSteps+1][6];
   logic [LenWidth:0]  d_rem_ff   [DivSteps+1][6];
   logic [DivSteps-1:0] d_quo_ff  [DivSteps+1][6];

   always_comb begin
      logic signed [VecWidth-1:0] v [6];
      logic [NumWidth-1:0] numv;
      v[0] = s_work_ff[SqSteps].nx;
      v[1] = s_work_ff[SqSteps].ny;
      v[2] = s_work_ff[SqSteps].nz;
      v[3] = light_x;
      v[4] = light_y;
      v[5] = light_z;
      d_valid_ff[0] = s_valid_ff[SqSteps];
      d_mag_ff[0] = s_work_ff[SqSteps].magenta;
      d_base_ff[0] = s_work_ff[SqSteps].base;
      d_nlen_ff[0] = s_nroot_ff[SqSteps];
      d_llen_ff[0] = s_lroot_ff[SqSteps];
      for (int i = 0; i < 6; i++) begin
         numv = NumWidth'({v[i][VecWidth-1] ? 17'(-v[i]) : 17'(v[i]), 12'd0});
         d_neg_ff[0][i] = v[i][VecWidth-1];
         d_num_ff[0][i] = {numv[DivSteps-1:0], 16'd0};
         d_rem_ff[0][i] = (LenWidth+1)'(numv[NumWidth-1:DivSteps]);
         d_quo_ff[0][i] = '0;
      end
   end

   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      for (genvar j = 0; j < 6; j++) begin : g_lane
         logic [LenWidth:0] sh, den;
         always_comb begin
            den = (j < 3) ? {1'b0, d_nlen_ff[k]} : {1'b0, d_llen_ff[k]};
            sh = {d_rem_ff[k][j][LenWidth-1:0], d_num_ff[k][j][NumWidth-1]};
         end
         always_ff @(posedge clock) begin
            d_num_ff[k+1][j] <= {d_num_ff[k][j][NumWidth-2:0], 1'b0};
            if (sh >= den && den != '0) begin
               d_rem_ff[k+1][j] <= sh - den;
               d_quo_ff[k+1][j] <= {d_quo_ff[k][j][DivSteps-2:0], 1'b1};
            end else begin
               d_rem_ff[k+1][j] <= sh;
               d_quo_ff[k+1][j] <= {d_quo_ff[k][j][DivSteps-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            d_valid_ff[k+1] <= 1'b0;
         end else begin
            d_valid_ff[k+1] <= d_valid_ff[k];
         end
         d_mag_ff[k+1] <= d_mag_ff[k];
         d_base_ff[k+1] <= d_base_ff[k];
         d_nlen_ff[k+1] <= d_nlen_ff[k];
         d_llen_ff[k+1] <= d_llen_ff[k];
         d_neg_ff[k+1] <= d_neg_ff[k];
      end
   end

   // stage P: products of normalized components
   logic               p_valid_ff;
   logic               p_mag_ff;
   logic [ColorWidth-1:0] p_base_ff;
   logic signed [36:0] p_prod_ff [3];
   logic signed [18:0] q [6];

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         q[i] = d_neg_ff[DivSteps][i] ? -19'(signed'({1'b0, d_quo_ff[DivSteps][i]}))
                                      : 19'(signed'({1'b0, d_quo_ff[DivSteps][i]}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= d_valid_ff[DivSteps];
      end
      p_mag_ff <= d_mag_ff[DivSteps];
      p_base_ff <= d_base_ff[DivSteps];
      for (int i = 0; i < 3; i++) begin
         p_prod_ff[i] <= 37'(q[i] * q[i+3]);
      end
   end

   // stage F: dot sum and light factor
   logic               f_valid_ff;
   logic               f_mag_ff;
   logic [ColorWidth-1:0] f_base_ff;
   logic [16:0]        f_factor_ff;
   logic signed [38:0] dot;
   logic [29:0]        fac_raw;
   logic [16:0]        fac;

   always_comb begin
      dot = 39'(p_prod_ff[0]) + 39'(p_prod_ff[1]) + 39'(p_prod_ff[2]);
      fac_raw = (dot > 0) ? dot[38:9] : '0;
      fac = (fac_raw > 30'(ambient)) ? 17'(fac_raw) : {1'b0, ambient};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= p_valid_ff;
      end
      f_mag_ff <= p_mag_ff;
      f_base_ff <= p_base_ff;
      f_factor_ff <= fac;
   end

   // stage C: channel scaling and saturation
   logic               c_valid_ff;
   logic [ColorWidth-1:0] c_color_ff, c_color_in;

   always_comb begin
      logic [24:0] prod;
      logic [9:0]  sc;
      for (int i = 0; i < 3; i++) begin
         prod = 25'(f_base_ff[8*i +: 8] * f_factor_ff);
         sc = prod[24:15];
         c_color_in[8*i +: 8] = (sc > 10'd255) ? 8'hFF : sc[7:0];
      end
      if (f_mag_ff) begin
         c_color_in = MagentaColor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= f_valid_ff;
      end
      c_color_ff <= c_color_in;
   end

   assign out_valid = c_valid_ff;
   assign out_color = c_color_ff;

`ifndef SYNTHESIS
   a_len_mag: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff[SqSteps] |-> (s_nrem_ff[SqSteps] <= (SqWidth+2)'({s_nroot_ff[SqSteps], 1'b0})))
      else $error("sqrt remainder too large");
   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |=> f_valid_ff)
      else $error("factor stage lost a word");
   a_magenta: assert property (@(posedge clock) disable iff (reset)
      (f_valid_ff && f_mag_ff) |=> (c_color_ff == MagentaColor))
      else $error("missing base not magenta");
`endif
endmodule

// ===== rtl/core/normal_map_pixel_lighting.sv =====
// Top level: csr registers, front part, back pipeline and result queue.
//
// Per-pixel diffuse lighting with an optional normal map.
// Input channel: req_* fields with push/full; a word is taken when push is
// high and full is low. Result channel: rsp_lit_color with empty/pop; the
// oldest result is shown while empty is low and taken when pop is high.
// Configuration: csr_we/csr_index/csr_wdata write one of light_x, light_y,
// light_z and ambient per cycle; write only while the block is idle.
// Throughput: one word per cycle while full is low. A word passes the
// front stage, the bit-per-stage square root (17 stages) and the
// bit-per-stage dividers (13 stages) that normalize both vectors, then
// the product, factor and scaling stages and the queue's registered read
// path before its result shows.
// A result queue behind the pipeline holds every word in flight; full is
// raised once 64 words are taken but not yet popped, so a stalled receiver
// backs up into the input channel without loss.
// Reset clears all valid state and loads the registers with their defaults.
module normal_map_pixel_lighting (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [23:0] req_base_texel,
   input  logic        req_base_present,
   input  logic [23:0] req_bump_texel,
   input  logic        req_bump_present,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   output logic        empty,
   input  logic        pop,
   output logic [23:0] rsp_lit_color,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import nmpl_pkg::*;

   localparam int unsigned QDepth = 64;
   localparam int unsigned QAw = 6;

   logic signed [15:0] light_x_ff, light_y_ff, light_z_ff;
   logic [15:0] ambient_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= 16'sd0;
         light_y_ff <= 16'sd0;
         light_z_ff <= 16'sd4096;
         ambient_ff <= 16'd6554;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrLightX:  light_x_ff <= csr_wdata;
            CsrLightY:  light_y_ff <= csr_wdata;
            CsrLightZ:  light_z_ff <= csr_wdata;
            CsrAmbient: ambient_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic accept;
   logic f_valid;
   work_type f_work;
   logic b_valid;
   logic [23:0] b_color;

   assign accept = push && !full;

   nmpl_front u_front (
      .clock, .reset, .in_valid(accept),
      .base_texel(req_base_texel), .base_present(req_base_present),
      .bump_texel(req_bump_texel), .bump_present(req_bump_present),
      .normal_x(req_normal_x), .normal_y(req_normal_y), .normal_z(req_normal_z),
      .out_valid(f_valid), .out_work(f_work)
   );

   nmpl_back u_back (
      .clock, .reset, .in_valid(f_valid), .in_work(f_work),
      .light_x(light_x_ff), .light_y(light_y_ff), .light_z(light_z_ff),
      .ambient(ambient_ff), .out_valid(b_valid), .out_color(b_color)
   );

   // result queue with credit count covering words in flight; the memory is
   // read into a register, then into a two-word output buffer
   logic [23:0] mem [QDepth];
   logic [QAw-1:0] wp_ff, rp_ff;
   logic [QAw:0] mcnt_ff, credit_ff;
   logic rd_valid_ff;
   logic [23:0] rd_data_ff;
   logic [23:0] ob_ff [2];
   logic ob_wp_ff, ob_rp_ff;
   logic [1:0] ocnt_ff;
   logic fetch;
   logic take;

   assign take = pop && !empty;
   assign empty = (ocnt_ff == 2'd0);
   assign full = (credit_ff >= (QAw+1)'(QDepth));
   assign rsp_lit_color = ob_ff[ob_rp_ff];
   // fetch only when the word lands in a buffer slot that is sure to be free
   assign fetch = (mcnt_ff != '0) &&
                  (({1'b0, ocnt_ff} + 3'(rd_valid_ff) - 3'(take)) <= 3'd1);

   always_ff @(posedge clock) begin
      if (b_valid) begin
         mem[wp_ff] <= b_color;
      end
      if (fetch) begin
         rd_data_ff <= mem[rp_ff];
      end
      if (rd_valid_ff) begin
         ob_ff[ob_wp_ff] <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         mcnt_ff <= '0;
         credit_ff <= '0;
         rd_valid_ff <= 1'b0;
         ob_wp_ff <= 1'b0;
         ob_rp_ff <= 1'b0;
         ocnt_ff <= '0;
      end else begin
         if (b_valid) wp_ff <= wp_ff + 1'b1;
         if (fetch) rp_ff <= rp_ff + 1'b1;
         mcnt_ff <= mcnt_ff + (QAw+1)'(b_valid) - (QAw+1)'(fetch);
         rd_valid_ff <= fetch;
         if (rd_valid_ff) ob_wp_ff <= ~ob_wp_ff;
         if (take) ob_rp_ff <= ~ob_rp_ff;
         ocnt_ff <= ocnt_ff + 2'(rd_valid_ff) - 2'(take);
         credit_ff <= credit_ff + (QAw+1)'(accept) - (QAw+1)'(take);
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, mcnt_ff} + 8'(ocnt_ff) + 8'(rd_valid_ff)) <= {1'b0, credit_ff})
      else $error("queue holds more words than credited");
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= (QAw+1)'(QDepth))
      else $error("credit over depth");
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= 2'd2)
      else $error("output buffer over two words");
   a_pop_drops: assert property (@(posedge clock) disable iff (reset)
      (take && !rd_valid_ff) |=> (ocnt_ff == $past(ocnt_ff) - 1'b1))
      else $error("pop not counted");
`endif
endmodule
